>>> rtl/kdls_pkg.sv
// ----------------------------------------------------------------------------
// kdls_pkg: shared types and constants for the key debounce scanner
// Field widths, register reset values, register indexes and lane structs.
// ----------------------------------------------------------------------------
package kdls_pkg;

   localparam int NUM_KEYS_DEFAULT = 4;
   localparam int KEY_LEVELS_W     = 4;   // keys that have an input bit
   localparam int DEB_W            = 8;
   localparam int HOLD_W           = 16;
   localparam int KEY_IDX_W        = 2;
   localparam int CSR_IDX_W        = 2;
   localparam int CSR_DATA_W       = 16;
   localparam int REQ_DATA_W       = 8;
   localparam int RSP_DATA_W       = 8;

   localparam logic [DEB_W-1:0]  RESET_DEBOUNCE  = 8'd3;
   localparam logic [HOLD_W-1:0] RESET_LONGPRESS = 16'd100;

   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LONGPRESS = 2'd1;

   // what one lane found on the current item
   typedef struct packed {
      logic fire;
      logic is_long;
   } lane_event_type;

   // merged result of one item
   typedef struct packed {
      logic                 valid;
      logic [KEY_IDX_W-1:0] key;
      logic                 is_long;
   } result_type;

   typedef struct packed {
      logic [DEB_W-1:0]  debounce_count;
      logic [HOLD_W-1:0] longpress_ticks;
   } cfg_type;

endpackage

>>> rtl/key_debounce_longpress_scanner.sv
// ----------------------------------------------------------------------------
// key_debounce_longpress_scanner: debounced key scanner with long-press repeat
// Turns sampled key levels into short-press and repeating long-press events.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one item per sample tick, key levels in req_tdata[3:0].
//   rsp_*  : one item back for every tick taken; rsp_tdata carries the
//            event flag and key index, rsp_tuser says whether it is a
//            long-press repeat. A tick without an event returns all zeros.
//   csr_*  : write-only registers, index 0 debounce count, index 1 hold
//            ticks between long-press repeats. Write them while idle.
// A tick's result is registered and shows in the cycle after it is taken.
// Throughput is one item per cycle while rsp_tready is high, set by the
// single output register; key lanes and the priority pick are combinational.
// When the receiver stalls, the output register holds its item and the
// request side stops taking ticks until it drains, so no tick is lost.
// Reset clears every key's stable level, counters and latch, empties the
// output register and loads the register defaults (3 and 100).
// ----------------------------------------------------------------------------
module key_debounce_longpress_scanner #(
   parameter int NUM_KEYS = kdls_pkg::NUM_KEYS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [kdls_pkg::REQ_DATA_W-1:0]     req_tdata,   // [3:0] key_levels
   // result channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [kdls_pkg::RSP_DATA_W-1:0]     rsp_tdata,   // [0] event_valid,
                                                            // [2:1] event_key
   output logic                                rsp_tuser,   // [0] event_long
   // configuration
   input  logic                                csr_we,
   input  logic [kdls_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [kdls_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int RAW_KEYS = (NUM_KEYS < kdls_pkg::KEY_LEVELS_W) ?
                             NUM_KEYS : kdls_pkg::KEY_LEVELS_W;

   kdls_pkg::cfg_type          cfg_ff, cfg_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   kdls_pkg::result_type       rsp_data_ff, rsp_data_in;

   logic                       req_fire;
   logic [NUM_KEYS-1:0]        raw_keys;
   logic [NUM_KEYS-1:0]        commit_mask;
   logic [NUM_KEYS-1:0]        fire_vec;
   kdls_pkg::lane_event_type   lane_ev [NUM_KEYS];
   kdls_pkg::result_type       merged;

   // ---- configuration registers ----
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            kdls_pkg::CSR_DEBOUNCE:
               cfg_in.debounce_count  = csr_wdata[kdls_pkg::DEB_W-1:0];
            kdls_pkg::CSR_LONGPRESS:
               cfg_in.longpress_ticks = csr_wdata[kdls_pkg::HOLD_W-1:0];
            default: ;  // drop writes to unknown indexes
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_count  <= kdls_pkg::RESET_DEBOUNCE;
         cfg_ff.longpress_ticks <= kdls_pkg::RESET_LONGPRESS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ---- request side: take a tick whenever the output can move on ----
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   // keys past the input bits read as released
   always_comb begin
      raw_keys = '0;
      raw_keys[RAW_KEYS-1:0] = req_tdata[RAW_KEYS-1:0];
   end

   // ---- one lane per key ----
   for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
      kdls_lane u_lane (
         .clock   (clock),
         .reset   (reset),
         .cfg     (cfg_ff),
         .raw     (raw_keys[k]),
         .commit  (req_fire && commit_mask[k]),
         .lane_ev (lane_ev[k])
      );
      assign fire_vec[k] = lane_ev[k].fire;
   end

   // ---- merge: lowest firing key wins, higher keys hold ----
   kdls_merge #(
      .NUM_KEYS (NUM_KEYS)
   ) u_merge (
      .lane_ev     (lane_ev),
      .commit_mask (commit_mask),
      .result      (merged)
   );

   // ---- output register ----
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = merged;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(kdls_pkg::RSP_DATA_W - kdls_pkg::KEY_IDX_W - 1){1'b0}},
                        rsp_data_ff.key, rsp_data_ff.valid};
   assign rsp_tuser  = rsp_data_ff.is_long;

   // ---- assertions ----
   a_one_winner: assert property (@(posedge clock) disable iff (reset)
      $countones(fire_vec & commit_mask) == (merged.valid ? 1 : 0))
      else $error("merged result does not match exactly one committing lane");

   a_no_take_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !req_fire)
      else $error("tick taken while the output item is stalled");

   a_quiet_result: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !merged.valid) |=> (rsp_valid_ff && rsp_data_ff == '0))
      else $error("tick without event gave a non-zero result");

   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid_ff)
      else $error("output register not empty after reset");

endmodule

>>> rtl/kdls_lane.sv
// ----------------------------------------------------------------------------
// kdls_lane: debounce and hold tracking for one key
// Works out the next state and the event of its key on every item; the state
// is written only when the merge stage lets this lane commit.
// ----------------------------------------------------------------------------
module kdls_lane (
   input  logic                      clock,
   input  logic                      reset,
   input  kdls_pkg::cfg_type         cfg,
   input  logic                      raw,
   input  logic                      commit,
   output kdls_pkg::lane_event_type  lane_ev
);

   logic                          stable_ff, stable_in;
   logic                          latched_ff, latched_in;
   logic [kdls_pkg::DEB_W-1:0]    deb_cnt_ff, deb_cnt_in;
   logic [kdls_pkg::HOLD_W-1:0]   hold_cnt_ff, hold_cnt_in;

   logic [kdls_pkg::DEB_W-1:0]    deb_inc;
   logic [kdls_pkg::HOLD_W-1:0]   hold_inc;

   // saturating increments
   assign deb_inc  = (deb_cnt_ff == '1) ? deb_cnt_ff : deb_cnt_ff + 1'b1;
   assign hold_inc = (hold_cnt_ff == '1) ? hold_cnt_ff : hold_cnt_ff + 1'b1;

   always_comb begin
      stable_in   = stable_ff;
      deb_cnt_in  = '0;
      latched_in  = latched_ff;
      hold_cnt_in = hold_cnt_ff;
      lane_ev     = '0;

      if (raw != stable_ff) begin
         if (deb_inc >= cfg.debounce_count) begin
            stable_in = raw;
         end else begin
            deb_cnt_in = deb_inc;
         end
      end

      if (stable_in && !latched_ff) begin
         latched_in   = 1'b1;
         hold_cnt_in  = '0;
         lane_ev.fire = 1'b1;
      end else if (!stable_in && latched_ff) begin
         latched_in  = 1'b0;
         hold_cnt_in = '0;
      end else if (stable_in && latched_ff) begin
         if (hold_inc >= cfg.longpress_ticks) begin
            hold_cnt_in     = '0;
            lane_ev.fire    = 1'b1;
            lane_ev.is_long = 1'b1;
         end else begin
            hold_cnt_in = hold_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stable_ff   <= 1'b0;
         latched_ff  <= 1'b0;
         deb_cnt_ff  <= '0;
         hold_cnt_ff <= '0;
      end else if (commit) begin
         stable_ff   <= stable_in;
         latched_ff  <= latched_in;
         deb_cnt_ff  <= deb_cnt_in;
         hold_cnt_ff <= hold_cnt_in;
      end
   end

endmodule

>>> rtl/kdls_merge.sv
// ----------------------------------------------------------------------------
// kdls_merge: priority pick across the key lanes
// The lowest firing key gives the result; lanes above it hold their state.
// ----------------------------------------------------------------------------
module kdls_merge #(
   parameter int NUM_KEYS = kdls_pkg::NUM_KEYS_DEFAULT
) (
   input  kdls_pkg::lane_event_type lane_ev [NUM_KEYS],
   output logic [NUM_KEYS-1:0]      commit_mask,
   output kdls_pkg::result_type     result
);

   always_comb begin
      logic found;
      found       = 1'b0;
      result      = '0;
      commit_mask = '0;
      for (int k = 0; k < NUM_KEYS; k++) begin
         commit_mask[k] = !found;
         if (!found && lane_ev[k].fire) begin
            found          = 1'b1;
            result.valid   = 1'b1;
            result.key     = kdls_pkg::KEY_IDX_W'(k);
            result.is_long = lane_ev[k].is_long;
         end
      end
   end

endmodule

>>> bench/key_debounce_longpress_scanner_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// key_debounce_longpress_scanner_test: self-checking bench for the key scanner
// Drives tick items of four key levels and predicts the debounced short-press
// and long-press repeat events tick by tick. Every result item is checked in
// order, across several register settings and several idling patterns.
// ----------------------------------------------------------------------------
module key_debounce_longpress_scanner_test;

   // indexes with no register behind them; writes there must change nothing
   localparam logic [kdls_pkg::CSR_IDX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [kdls_pkg::CSR_IDX_W-1:0] CSR_SPARE_3 = 2'd3;
   localparam int MAX_PRINTED = 40;

   typedef enum logic [1:0] {PRESS_NONE, PRESS_SHORT, PRESS_LONG} press_kind_type;

   logic                                 clock = 1'b0;
   logic                                 reset;
   logic                                 req_tvalid;
   logic                                 req_tready;
   logic [kdls_pkg::REQ_DATA_W-1:0]      req_tdata;   // [3:0] key_levels
   logic                                 rsp_tvalid;
   logic                                 rsp_tready = 1'b0;
   logic [kdls_pkg::RSP_DATA_W-1:0]      rsp_tdata;   // [0] event_valid,
                                                      // [2:1] event_key
   logic                                 rsp_tuser;   // [0] event_long
   logic                                 csr_we;
   logic [kdls_pkg::CSR_IDX_W-1:0]       csr_index;
   logic [kdls_pkg::CSR_DATA_W-1:0]      csr_wdata;

   // bench copy of the scanner: registers and per-key state
   logic [kdls_pkg::DEB_W-1:0]  cfg_debounce;
   logic [kdls_pkg::HOLD_W-1:0] cfg_hold;
   logic                        key_stable  [kdls_pkg::NUM_KEYS_DEFAULT];
   logic [kdls_pkg::DEB_W-1:0]  deb_cnt     [kdls_pkg::NUM_KEYS_DEFAULT];
   logic                        key_latched [kdls_pkg::NUM_KEYS_DEFAULT];
   logic [kdls_pkg::HOLD_W-1:0] hold_cnt    [kdls_pkg::NUM_KEYS_DEFAULT];

   kdls_pkg::result_type pending_results[$];   // events predicted, not yet seen

   int req_gap_pct   = 0;
   int rsp_stall_pct = 0;
   int fail_count    = 0;
   int tick_count    = 0;
   int short_count   = 0;
   int long_count    = 0;
   int setting_count = 0;

   key_debounce_longpress_scanner u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   // receiver: stall at random, at the rate the current idling pattern sets
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   task automatic report_mismatch(input string what);
      if (fail_count < MAX_PRINTED) begin
         $display("mismatch at %0t ns: %s", $time, what);
      end
      fail_count++;
   endtask

   function automatic void clear_scanner_state();
      cfg_debounce = kdls_pkg::RESET_DEBOUNCE;
      cfg_hold     = kdls_pkg::RESET_LONGPRESS;
      for (int k = 0; k < kdls_pkg::NUM_KEYS_DEFAULT; k++) begin
         key_stable[k]  = 1'b0;
         deb_cnt[k]     = '0;
         key_latched[k] = 1'b0;
         hold_cnt[k]    = '0;
      end
   endfunction

   // Advance every key by one tick in index order. The first key with an
   // event claims the tick; keys above it keep their state untouched.
   function automatic kdls_pkg::result_type scan_keys(
      input logic [kdls_pkg::KEY_LEVELS_W-1:0] levels
   );
      kdls_pkg::result_type found;
      press_kind_type       kind;
      logic                 raw;
      logic                 claimed;
      found   = '0;
      claimed = 1'b0;
      for (int k = 0; k < kdls_pkg::NUM_KEYS_DEFAULT; k++) begin
         if (!claimed) begin
            raw = levels[k];
            if (raw != key_stable[k]) begin
               if (deb_cnt[k] != '1) begin
                  deb_cnt[k] = deb_cnt[k] + 1'b1;
               end
               // ">=" so a lowered or zero count adopts at once
               if (deb_cnt[k] >= cfg_debounce) begin
                  key_stable[k] = raw;
                  deb_cnt[k]    = '0;
               end
            end else begin
               deb_cnt[k] = '0;
            end
            kind = PRESS_NONE;
            if (key_stable[k] && !key_latched[k]) begin
               key_latched[k] = 1'b1;
               hold_cnt[k]    = '0;
               kind           = PRESS_SHORT;
            end else if (!key_stable[k] && key_latched[k]) begin
               key_latched[k] = 1'b0;
               hold_cnt[k]    = '0;
            end else if (key_stable[k] && key_latched[k]) begin
               if (hold_cnt[k] != '1) begin
                  hold_cnt[k] = hold_cnt[k] + 1'b1;
               end
               if (hold_cnt[k] >= cfg_hold) begin
                  hold_cnt[k] = '0;
                  kind        = PRESS_LONG;
               end
            end
            if (kind != PRESS_NONE) begin
               found.valid   = 1'b1;
               found.key     = k[kdls_pkg::KEY_IDX_W-1:0];
               found.is_long = (kind == PRESS_LONG);
               claimed       = 1'b1;
            end
         end
      end
      return found;
   endfunction

   task automatic set_idling(input int gap_pct, input int stall_pct);
      req_gap_pct   = gap_pct;
      rsp_stall_pct = stall_pct;
   endtask

   // Offer one tick item, hold it until taken, then log its expected event.
   // Enter and leave on a falling edge.
   task automatic send_tick(input logic [kdls_pkg::KEY_LEVELS_W-1:0] levels);
      kdls_pkg::result_type want;
      while ($urandom_range(0, 99) < req_gap_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(kdls_pkg::REQ_DATA_W - kdls_pkg::KEY_LEVELS_W){1'b0}}, levels};
      do @(posedge clock); while (!req_tready);
      want = scan_keys(levels);
      pending_results.push_back(want);
      tick_count++;
      if (want.valid && want.is_long) begin
         long_count++;
      end else if (want.valid) begin
         short_count++;
      end
      @(negedge clock);
   endtask

   // Drop valid and hold off until every expected event has come back.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   // Drop the write enable after each write and wait with it low.
   task automatic write_csr(input logic [kdls_pkg::CSR_IDX_W-1:0]  index,
                            input logic [kdls_pkg::CSR_DATA_W-1:0] value);
      drain_results();
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
      case (index)
         kdls_pkg::CSR_DEBOUNCE: begin
            cfg_debounce = value[kdls_pkg::DEB_W-1:0];
            setting_count++;
         end
         kdls_pkg::CSR_LONGPRESS: begin
            cfg_hold = value[kdls_pkg::HOLD_W-1:0];
            setting_count++;
         end
         default: ;
      endcase
   endtask

   // Check each result item against the oldest expectation.
   always @(posedge clock) begin
      kdls_pkg::result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("result %h/%b with nothing pending",
                                      rsp_tdata, rsp_tuser));
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata[0] !== want.valid) begin
               report_mismatch($sformatf("event_valid %b, want %b",
                                         rsp_tdata[0], want.valid));
            end
            if (rsp_tdata[2:1] !== want.key) begin
               report_mismatch($sformatf("event_key %0d, want %0d",
                                         rsp_tdata[2:1], want.key));
            end
            if (rsp_tuser !== want.is_long) begin
               report_mismatch($sformatf("event_long %b, want %b",
                                         rsp_tuser, want.is_long));
            end
            if (rsp_tdata[kdls_pkg::RSP_DATA_W-1:3] !== '0) begin
               report_mismatch($sformatf("padding bits %b not zero",
                                         rsp_tdata[kdls_pkg::RSP_DATA_W-1:3]));
            end
         end
      end
   end

   // Default registers: simultaneous presses resolve one key per tick,
   // releases give no event, bounces shorter than the count are dropped.
   task automatic test_default_registers();
      logic [kdls_pkg::KEY_LEVELS_W-1:0] seq[$] =
         '{4'h0, 4'h0, 4'hF, 4'hF, 4'hF, 4'hF,
           4'hF, 4'hF, 4'hF, 4'h0, 4'h0, 4'h0,
           4'h8, 4'h0, 4'h8, 4'h8, 4'h8, 4'h0};
      foreach (seq[i]) send_tick(seq[i]);
   endtask

   // Zero counts: adopt after one tick, repeat the long press every tick.
   task automatic test_zero_registers();
      write_csr(kdls_pkg::CSR_DEBOUNCE, 16'h0000);
      write_csr(kdls_pkg::CSR_LONGPRESS, 16'h0000);
      repeat (4) send_tick(4'h5);
      repeat (3) send_tick(4'hA);
      send_tick(4'h0);
   endtask

   // Writes to unused indexes must leave both registers as they were.
   task automatic test_spare_indexes();
      write_csr(kdls_pkg::CSR_DEBOUNCE, 16'h0002);
      write_csr(kdls_pkg::CSR_LONGPRESS, 16'h0003);
      write_csr(CSR_SPARE_2, 16'hFFFF);
      write_csr(CSR_SPARE_3, 16'($urandom_range(0, 65535)));
      repeat (5) send_tick(4'h2);
      send_tick(4'h0);
   endtask

   // Largest counts, then lower each register while keys sit mid-count:
   // the next held or differing tick must fire at once.
   task automatic test_extreme_registers();
      logic [kdls_pkg::KEY_LEVELS_W-1:0] held;
      held = 4'($urandom_range(1, 15));
      write_csr(kdls_pkg::CSR_DEBOUNCE, 16'h00FF);
      write_csr(kdls_pkg::CSR_LONGPRESS, 16'hFFFF);
      repeat (300) send_tick(held);
      repeat (40) send_tick(~held);
      write_csr(kdls_pkg::CSR_LONGPRESS, 16'h0001);
      repeat (3) send_tick(~held);
      write_csr(kdls_pkg::CSR_DEBOUNCE, 16'h0004);
      repeat (30) send_tick(~held);
   endtask

   // Runs of steady key masks with random content, sprinkled with single-key
   // bounces and pure noise ticks, over many register settings.
   task automatic test_random_sequences();
      logic [kdls_pkg::KEY_LEVELS_W-1:0] mask;
      logic [kdls_pkg::KEY_LEVELS_W-1:0] levels;
      logic [kdls_pkg::DEB_W-1:0]        deb;
      logic [kdls_pkg::HOLD_W-1:0]       hold;
      int                                run_len;
      int                                sent;
      int                                roll;
      for (int phase = 0; phase < 9; phase++) begin
         case (phase / 3)
            0:       set_idling(13, 55);
            1:       set_idling(55, 13);
            default: set_idling(0, 0);
         endcase
         case ($urandom_range(0, 5))
            0:       deb = 8'd0;
            1:       deb = 8'd1;
            default: deb = 8'($urandom_range(2, 6));
         endcase
         case ($urandom_range(0, 5))
            0:       hold = 16'd0;
            1:       hold = 16'd1;
            default: hold = 16'($urandom_range(2, 30));
         endcase
         // upper byte of the debounce write is junk the block must drop
         write_csr(kdls_pkg::CSR_DEBOUNCE, {8'($urandom_range(0, 255)), deb});
         write_csr(kdls_pkg::CSR_LONGPRESS, hold);
         sent = 0;
         while (sent < 130) begin
            if ($urandom_range(0, 99) == 0) begin
               drain_results();
            end
            mask    = 4'($urandom_range(0, 15));
            run_len = $urandom_range(1, deb + 2 * hold + 6);
            if (run_len > 80) begin
               run_len = 80;
            end
            repeat (run_len) begin
               levels = mask;
               roll   = $urandom_range(0, 99);
               if (roll < 8) begin
                  levels[$urandom_range(0, kdls_pkg::KEY_LEVELS_W - 1)] ^= 1'b1;
               end else if (roll < 12) begin
                  levels = 4'($urandom_range(0, 15));
               end
               send_tick(levels);
               sent++;
            end
         end
      end
   endtask

   // Hard stop well beyond the slowest legal run.
   initial begin
      #2000000;
      $display("tb: failure");
      $finish;
   end

   initial begin
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_we     = 1'b0;
      csr_index  = kdls_pkg::CSR_DEBOUNCE;
      csr_wdata  = '0;
      reset      = 1'b1;
      clear_scanner_state();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      set_idling(13, 55);
      test_default_registers();
      test_zero_registers();
      test_spare_indexes();
      test_extreme_registers();
      test_random_sequences();

      // let the last result drain, then keep watching the output for strays
      drain_results();
      repeat (4) @(negedge clock);

      $display("run: %0d ticks, %0d short and %0d long-press events expected",
               tick_count, short_count, long_count);
      $display("run: %0d register writes, %0d mismatches", setting_count, fail_count);
      if (fail_count == 0 && pending_results.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/kdls_pkg.sv
rtl/kdls_lane.sv
rtl/kdls_merge.sv
rtl/key_debounce_longpress_scanner.sv
bench/key_debounce_longpress_scanner_test.sv
